// ===== hdl/local_maximum_marker_3x3_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 local maximum marker
// Wraps concurrent assertions so that synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef LOCAL_MAXIMUM_MARKER_3X3_MACROS_SVH
`define LOCAL_MAXIMUM_MARKER_3X3_MACROS_SVH
`ifndef SYNTHESIS
`define LMM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication does not hold");
`define LMM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle condition does not hold");
`define LMM_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: forbidden condition seen");
`else
`define LMM_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define LMM_ASSERT_NEXT(label, clk, rst, ante, cons)
`define LMM_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// ===== hdl/lmm_pkg.sv =====
// ----------------------------------------------------------------------------
// lmm_pkg
// Shared constants and types of the 3x3 local maximum marker.
// ----------------------------------------------------------------------------
`default_nettype none

package lmm_pkg;

   localparam int FIELD_W      = 16;
   localparam int PIX_W        = 3 * FIELD_W;
   localparam int TDATA_W      = ((PIX_W + 7) / 8) * 8;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int MARKER_W     = 16;
   localparam int ROW_W        = 13;
   localparam int WINDOW_COLS  = 3;
   localparam int QUEUE_DEPTH  = 4;

   localparam int DEF_MAX_WIDTH    = 1024;
   localparam int DEF_CHANNEL_BITS = 16;

   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_LIMIT = 13'd4096;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MARKER_VALUE = 2'd2;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [MARKER_W-1:0]     MARKER_RESET = 16'd255;

   // Neighbor-versus-center flags of one window column.
   typedef struct packed {
      logic top;
      logic mid;
      logic bot;
   } lmm_ge_type;

   typedef struct packed {
      logic [FIELD_W-1:0] red;
      logic [FIELD_W-1:0] green;
      logic [FIELD_W-1:0] blue;
      logic               is_maximum;
      logic               frame_end;
   } lmm_result_type;

endpackage

`default_nettype wire

// ===== hdl/local_maximum_marker_3x3.sv =====
// ----------------------------------------------------------------------------
// local_maximum_marker_3x3
// Streams RGB pixels in raster order and marks strict 3x3 local maxima of
// the red channel. Pixels leave one row plus one pixel behind the input.
//
//   channel   direction   beat contents
//   req_*     in          tdata: red, green, blue; tuser: action (1 = flush)
//   rsp_*     out         tdata: red, green, blue; tuser: is_maximum;
//                         tlast: frame_end
//   csr_*     in          index and data of one register write
//
// One item is accepted per clock when the rsp side keeps up; a result is
// offered on the rsp side after the line store read, window and queue registers.
// The rate is set by the two line stores, each read and written once per item.
// A four-entry result queue absorbs rsp stalls; req_tready drops once the
// queue plus the results still in the window pipeline reach four.
// Reset clears counters and control only; the line stores are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module local_maximum_marker_3x3
   import lmm_pkg::*;
#(
   parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
   parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   // req_tdata: red_in [15:0], green_in [31:16], blue_in [47:32]
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [TDATA_W-1:0]      req_tdata,
   // req_tuser: action [0]
   input  logic                    req_tuser,
   // rsp_tdata: red_out [15:0], green_out [31:16], blue_out [47:32]
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [TDATA_W-1:0]      rsp_tdata,
   // rsp_tuser: is_maximum [0]
   output logic                    rsp_tuser,
   output logic                    rsp_tlast,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

`include "local_maximum_marker_3x3_macros.svh"

   localparam int CH     = CHANNEL_BITS;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WID_W  = $clog2(MAX_WIDTH + 1);
   localparam int WCMP_W = (WID_W > WIDTH_REG_W) ? WID_W : WIDTH_REG_W;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CMT_W  = QCNT_W + 1;

   // Configuration registers.
   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic [MARKER_W-1:0]     marker_ff;
   logic                    csr_write;
   logic                    size_write;

   logic [WID_W-1:0]        used_w;
   logic [ROW_W-1:0]        used_h;

   // Input side position counters.
   logic [COL_W-1:0]        in_col_ff;
   logic [COL_W-1:0]        in_col_in;
   logic [ROW_W-1:0]        in_row_ff;
   logic [ROW_W-1:0]        in_row_in;

   logic                    accept;
   logic                    all_in;
   logic                    step;
   logic [3*CH-1:0]         pix;
   logic [WID_W-1:0]        col_inc;
   logic                    col_wrap;
   logic                    emit;
   logic [ROW_W-1:0]        er;
   logic [WID_W-1:0]        ec;
   logic                    interior;
   logic                    frame_last;
   logic                    restart;

   // Line store read stage.
   logic                    b_valid_ff;
   logic                    b_emit_ff;
   logic                    b_interior_ff;
   logic                    b_last_ff;
   logic [COL_W-1:0]        b_col_ff;
   logic [CH-1:0]           b_red_ff;
   logic [3*CH-1:0]         mid_rd;
   logic [CH-1:0]           top_rd;

   // Window stage.
   logic                    w_emit_ff;
   logic                    w_interior_ff;
   logic                    w_last_ff;

   logic [CH-1:0]           link_top [WINDOW_COLS];
   logic [3*CH-1:0]         link_mid [WINDOW_COLS];
   logic [CH-1:0]           link_bot [WINDOW_COLS];
   logic [CH-1:0]           cell_top [WINDOW_COLS];
   logic [3*CH-1:0]         cell_mid [WINDOW_COLS];
   logic [CH-1:0]           cell_bot [WINDOW_COLS];
   lmm_ge_type              cell_ge  [WINDOW_COLS];
   logic [CH-1:0]           center_red;
   logic                    is_max;
   lmm_result_type          result;
   lmm_result_type          rsp_result;

   logic [QCNT_W-1:0]       q_count;
   logic [CMT_W-1:0]        committed;

   // ------------------------------------------------------------------------
   // Configuration
   // ------------------------------------------------------------------------
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign size_write = csr_write &&
                       (csr_index == CSR_FRAME_WIDTH || csr_index == CSR_FRAME_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         marker_ff <= MARKER_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_ff  <= csr_data[WIDTH_REG_W-1:0];
            CSR_FRAME_HEIGHT: height_ff <= csr_data[HEIGHT_REG_W-1:0];
            CSR_MARKER_VALUE: marker_ff <= csr_data[MARKER_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         used_w = WID_W'(1);
      end else if (WCMP_W'(width_ff) > WCMP_W'(MAX_WIDTH)) begin
         used_w = WID_W'(MAX_WIDTH);
      end else begin
         used_w = WID_W'(width_ff);
      end
      if (height_ff == '0) begin
         used_h = ROW_W'(1);
      end else if (height_ff > HEIGHT_LIMIT) begin
         used_h = ROW_W'(HEIGHT_LIMIT);
      end else begin
         used_h = ROW_W'(height_ff);
      end
   end

   // ------------------------------------------------------------------------
   // Input stage: position tracking and line store access
   // ------------------------------------------------------------------------
   assign accept = req_tvalid && req_tready;
   assign all_in = in_row_ff >= used_h;
   // A flush while pixels are still expected is taken and dropped.
   assign step   = accept && !(req_tuser && !all_in);

   always_comb begin
      if (all_in) begin
         pix = '0;
      end else begin
         pix = {req_tdata[2*FIELD_W +: CH], req_tdata[FIELD_W +: CH], req_tdata[0 +: CH]};
      end
   end

   assign col_inc  = WID_W'(in_col_ff) + WID_W'(1);
   assign col_wrap = col_inc >= used_w;
   assign emit     = (in_row_ff >= ROW_W'(2)) ||
                     (in_row_ff == ROW_W'(1) && in_col_ff != '0);

   // Position of the pixel that leaves with this item.
   always_comb begin
      if (in_col_ff != '0) begin
         er = in_row_ff - ROW_W'(1);
         ec = WID_W'(in_col_ff) - WID_W'(1);
      end else begin
         er = in_row_ff - ROW_W'(2);
         ec = used_w - WID_W'(1);
      end
   end

   assign interior   = (er >= ROW_W'(1)) && (er + ROW_W'(1) < used_h) &&
                       (ec >= WID_W'(1)) && (ec + WID_W'(1) < used_w);
   assign frame_last = (er == used_h - ROW_W'(1)) && (ec == used_w - WID_W'(1));
   assign restart    = step && emit && frame_last;

   always_comb begin
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      if (size_write || restart) begin
         in_col_in = '0;
         in_row_in = '0;
      end else if (step) begin
         if (col_wrap) begin
            in_col_in = '0;
            in_row_in = in_row_ff + ROW_W'(1);
         end else begin
            in_col_in = col_inc[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff <= '0;
         in_row_ff <= '0;
      end else begin
         in_col_ff <= in_col_in;
         in_row_ff <= in_row_in;
      end
   end

   lmm_line_store #(
      .DATA_W (3 * CH),
      .DEPTH  (MAX_WIDTH)
   ) u_middle_store (
      .clock   (clock),
      .wr_en   (step),
      .wr_addr (in_col_ff),
      .wr_data (pix),
      .rd_en   (step),
      .rd_addr (in_col_ff),
      .rd_data (mid_rd)
   );

   // The row above moves up one store once its old entry has been read.
   lmm_line_store #(
      .DATA_W (CH),
      .DEPTH  (MAX_WIDTH)
   ) u_upper_store (
      .clock   (clock),
      .wr_en   (b_valid_ff),
      .wr_addr (b_col_ff),
      .wr_data (mid_rd[CH-1:0]),
      .rd_en   (step),
      .rd_addr (in_col_ff),
      .rd_data (top_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         b_emit_ff  <= 1'b0;
         w_emit_ff  <= 1'b0;
      end else begin
         b_valid_ff <= step;
         b_emit_ff  <= step && emit;
         w_emit_ff  <= b_valid_ff && b_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         b_interior_ff <= interior;
         b_last_ff     <= frame_last;
         b_col_ff      <= in_col_ff;
         b_red_ff      <= pix[CH-1:0];
      end
      if (b_valid_ff) begin
         w_interior_ff <= b_interior_ff;
         w_last_ff     <= b_last_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Window: a chain of column cells, the newest column enters at the end
   // ------------------------------------------------------------------------
   assign center_red = cell_mid[1][CH-1:0];

   for (genvar gi = 0; gi < WINDOW_COLS; gi++) begin : g_col
      if (gi == WINDOW_COLS - 1) begin : g_feed
         assign link_top[gi] = top_rd;
         assign link_mid[gi] = mid_rd;
         assign link_bot[gi] = b_red_ff;
      end else begin : g_link
         assign link_top[gi] = cell_top[gi+1];
         assign link_mid[gi] = cell_mid[gi+1];
         assign link_bot[gi] = cell_bot[gi+1];
      end

      lmm_window_cell #(
         .CHANNEL_BITS (CH)
      ) u_cell (
         .clock        (clock),
         .shift_en     (b_valid_ff),
         .load_top_red (link_top[gi]),
         .load_mid_pix (link_mid[gi]),
         .load_bot_red (link_bot[gi]),
         .center_red   (center_red),
         .top_red      (cell_top[gi]),
         .mid_pix      (cell_mid[gi]),
         .bot_red      (cell_bot[gi]),
         .ge           (cell_ge[gi])
      );
   end

   // The center cell's own middle flag compares the center with itself.
   assign is_max = w_interior_ff &&
                   !(cell_ge[0].top || cell_ge[0].mid || cell_ge[0].bot ||
                     cell_ge[1].top || cell_ge[1].bot ||
                     cell_ge[2].top || cell_ge[2].mid || cell_ge[2].bot);

   always_comb begin
      result.is_maximum = is_max;
      result.frame_end  = w_last_ff;
      if (is_max) begin
         result.red   = FIELD_W'(marker_ff[CH-1:0]);
         result.green = '0;
         result.blue  = '0;
      end else begin
         result.red   = FIELD_W'(cell_mid[1][CH-1:0]);
         result.green = FIELD_W'(cell_mid[1][CH +: CH]);
         result.blue  = FIELD_W'(cell_mid[1][2*CH +: CH]);
      end
   end

   // ------------------------------------------------------------------------
   // Result queue and flow control
   // ------------------------------------------------------------------------
   lmm_out_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (w_emit_ff),
      .push_data (result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_result),
      .count     (q_count)
   );

   // Results already promised: queued plus still in the window pipeline.
   assign committed  = CMT_W'(q_count) + CMT_W'(b_emit_ff) + CMT_W'(w_emit_ff);
   assign req_tready = committed < CMT_W'(QUEUE_DEPTH);

   assign rsp_tdata = TDATA_W'({rsp_result.blue, rsp_result.green, rsp_result.red});
   assign rsp_tuser = rsp_result.is_maximum;
   assign rsp_tlast = rsp_result.frame_end;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `LMM_ASSERT_NEVER(a_col_in_range, clock, reset, WID_W'(in_col_ff) >= used_w)
   `LMM_ASSERT_NEXT(a_restart_clears, clock, reset, restart, in_col_ff == '0 && in_row_ff == '0)
   `LMM_ASSERT_NEVER(a_queue_bound, clock, reset, committed > CMT_W'(QUEUE_DEPTH))

endmodule

`default_nettype wire

// ===== hdl/lmm_line_store.sv =====
// ----------------------------------------------------------------------------
// lmm_line_store
// One row of pixel data: one write port, one read port, registered read.
// A read and a write of the same entry in one cycle return the old data.
// ----------------------------------------------------------------------------
`default_nettype none

module lmm_line_store
   import lmm_pkg::*;
#(
   parameter int DATA_W = PIX_W,
   parameter int DEPTH  = DEF_MAX_WIDTH
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [DATA_W-1:0]          wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [DATA_W-1:0]          rd_data
);

   logic [DATA_W-1:0] store_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/lmm_window_cell.sv =====
// ----------------------------------------------------------------------------
// lmm_window_cell
// One column of the 3x3 window. Takes its neighbor's column on each step
// and compares its own red values against the window center.
// ----------------------------------------------------------------------------
`default_nettype none

module lmm_window_cell
   import lmm_pkg::*;
#(
   parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
   input  logic                        clock,
   input  logic                        shift_en,
   input  logic [CHANNEL_BITS-1:0]     load_top_red,
   input  logic [3*CHANNEL_BITS-1:0]   load_mid_pix,
   input  logic [CHANNEL_BITS-1:0]     load_bot_red,
   input  logic [CHANNEL_BITS-1:0]     center_red,
   output logic [CHANNEL_BITS-1:0]     top_red,
   output logic [3*CHANNEL_BITS-1:0]   mid_pix,
   output logic [CHANNEL_BITS-1:0]     bot_red,
   output lmm_ge_type                  ge
);

   logic [CHANNEL_BITS-1:0]   top_red_ff;
   logic [CHANNEL_BITS-1:0]   top_red_in;
   logic [3*CHANNEL_BITS-1:0] mid_pix_ff;
   logic [3*CHANNEL_BITS-1:0] mid_pix_in;
   logic [CHANNEL_BITS-1:0]   bot_red_ff;
   logic [CHANNEL_BITS-1:0]   bot_red_in;

   assign top_red_in = shift_en ? load_top_red : top_red_ff;
   assign mid_pix_in = shift_en ? load_mid_pix : mid_pix_ff;
   assign bot_red_in = shift_en ? load_bot_red : bot_red_ff;

   always_ff @(posedge clock) begin
      top_red_ff <= top_red_in;
      mid_pix_ff <= mid_pix_in;
      bot_red_ff <= bot_red_in;
   end

   assign top_red = top_red_ff;
   assign mid_pix = mid_pix_ff;
   assign bot_red = bot_red_ff;

   // A neighbor at least as bright as the center rules out a strict maximum.
   assign ge.top = top_red_ff >= center_red;
   assign ge.mid = mid_pix_ff[CHANNEL_BITS-1:0] >= center_red;
   assign ge.bot = bot_red_ff >= center_red;

endmodule

`default_nettype wire

// ===== hdl/lmm_out_queue.sv =====
// ----------------------------------------------------------------------------
// lmm_out_queue
// Small result queue that decouples the window pipeline from the rsp side.
// ----------------------------------------------------------------------------
`default_nettype none

module lmm_out_queue
   import lmm_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  lmm_result_type               push_data,
   output logic                         out_valid,
   input  logic                         out_ready,
   output lmm_result_type               out_data,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lmm_result_type   entries_ff [DEPTH];
   logic [PTR_W-1:0] head_ff;
   logic [PTR_W-1:0] head_in;
   logic [PTR_W-1:0] tail_ff;
   logic [PTR_W-1:0] tail_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             pop;

   assign out_valid = count_ff != '0;
   assign pop       = out_valid && out_ready;
   assign out_data  = entries_ff[head_ff];
   assign count     = count_ff;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      if (pop) begin
         head_in = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
      end
      if (push) begin
         tail_in = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[tail_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== sim/local_maximum_marker_3x3_tb.sv =====
// ----------------------------------------------------------------------------
// local_maximum_marker_3x3_tb
// Self-checking bench for the streaming 3x3 local maximum marker. Pixel and
// flush beats go in through the req stream while a behavioral copy of the
// line stores and window predicts every emitted pixel. The checker compares
// each rsp beat field by field against the oldest prediction. Frame sizes
// and the marker level change between frames, the marker also mid-frame,
// and both streams stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module local_maximum_marker_3x3_tb;
   import lmm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH   = DEF_MAX_WIDTH;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_BEATS  = 620;
   localparam int IDLE_PCT      = 34;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [TDATA_W-1:0]     req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [TDATA_W-1:0]     rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   local_maximum_marker_3x3 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("local_maximum_marker_3x3_tb: errors");
      $finish;
   end

   // Shadow copy of the block: line stores, window and frame position.
   logic [FIELD_W-1:0]      upper_red  [STORE_DEPTH];
   logic [PIX_W-1:0]        middle_pix [STORE_DEPTH];
   logic [PIX_W-1:0]        window     [9];
   int unsigned             next_col;
   int unsigned             next_row;
   logic [WIDTH_REG_W-1:0]  width_reg;
   logic [HEIGHT_REG_W-1:0] height_reg;
   logic [MARKER_W-1:0]     marker_reg;

   lmm_result_type expected_pixels[$];
   int unsigned    effective_beats = 0;
   int unsigned    error_count = 0;
   bit             gaps_on = 1'b1;

   function automatic int unsigned active_width();
      if (width_reg == 0) return 1;
      if (width_reg > STORE_DEPTH) return STORE_DEPTH;
      return int'(width_reg);
   endfunction

   function automatic int unsigned active_height();
      if (height_reg == 0) return 1;
      if (height_reg > HEIGHT_LIMIT) return int'(HEIGHT_LIMIT);
      return int'(height_reg);
   endfunction

   function automatic logic [PIX_W-1:0] random_pixel(input int unsigned red_span);
      logic [FIELD_W-1:0] red;
      red = (red_span == 0) ? FIELD_W'($urandom) : FIELD_W'($urandom_range(red_span));
      return {FIELD_W'($urandom), FIELD_W'($urandom), red};
   endfunction

   task automatic reset_prediction();
      for (int i = 0; i < STORE_DEPTH; i++) begin
         upper_red[i]  = '0;
         middle_pix[i] = '0;
      end
      for (int i = 0; i < 9; i++) window[i] = '0;
      next_col   = 0;
      next_row   = 0;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      marker_reg = MARKER_RESET;
   endtask

   task automatic apply_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_FRAME_WIDTH: begin
            width_reg = data[WIDTH_REG_W-1:0];
            next_col  = 0;
            next_row  = 0;
         end
         CSR_FRAME_HEIGHT: begin
            height_reg = data[HEIGHT_REG_W-1:0];
            next_col   = 0;
            next_row   = 0;
         end
         CSR_MARKER_VALUE: marker_reg = data[MARKER_W-1:0];
         default: ;
      endcase
   endtask

   // Advances the shadow copy by one accepted beat and queues the pixel it
   // releases, if any.
   task automatic predict_marked_pixel(input bit flush, input logic [PIX_W-1:0] beat_pixel);
      int unsigned    w, h, col, er, ec, k;
      bit             all_in, emit, is_max;
      logic [PIX_W-1:0] pix, top, mid, centre;
      lmm_result_type res;
      w = active_width();
      h = active_height();
      all_in = next_row >= h;
      // A flush while pixels of the frame are still due changes nothing.
      if (flush && !all_in) return;
      effective_beats++;
      pix = (flush || all_in) ? '0 : beat_pixel;
      col = next_col % STORE_DEPTH;
      top = '0;
      top[FIELD_W-1:0] = upper_red[col];
      mid = middle_pix[col];
      upper_red[col]  = mid[FIELD_W-1:0];
      middle_pix[col] = pix;
      for (k = 0; k < 3; k++) begin
         window[k*3]   = window[k*3+1];
         window[k*3+1] = window[k*3+2];
      end
      window[2] = top;
      window[5] = mid;
      window[8] = pix;
      emit = next_row >= 2 || (next_row == 1 && next_col >= 1);
      if (next_col >= 1) begin
         er = next_row - 1;
         ec = next_col - 1;
      end else begin
         er = next_row - 2;
         ec = w - 1;
      end
      next_col++;
      if (next_col >= w) begin
         next_col = 0;
         next_row++;
      end
      if (!emit) return;
      centre = window[4];
      is_max = er >= 1 && er + 1 < h && ec >= 1 && ec + 1 < w;
      for (k = 0; k < 9; k++) begin
         if (k != 4 && window[k][FIELD_W-1:0] >= centre[FIELD_W-1:0]) is_max = 1'b0;
      end
      if (is_max) begin
         res.red        = marker_reg;
         res.green      = '0;
         res.blue       = '0;
         res.is_maximum = 1'b1;
      end else begin
         res.red        = centre[FIELD_W-1:0];
         res.green      = centre[2*FIELD_W-1:FIELD_W];
         res.blue       = centre[3*FIELD_W-1:2*FIELD_W];
         res.is_maximum = 1'b0;
      end
      res.frame_end = (er == h - 1) && (ec == w - 1);
      if (res.frame_end) begin
         next_col = 0;
         next_row = 0;
      end
      expected_pixels.push_back(res);
   endtask

   task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] got,
                                  input logic [FIELD_W-1:0] want);
      $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   // Result checker; also throttles the rsp side.
   always @(posedge clock) begin
      lmm_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("rsp beat with nothing expected", rsp_tdata[FIELD_W-1:0], '0);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_tdata[FIELD_W-1:0] !== want.red)
               report_mismatch("red_out", rsp_tdata[FIELD_W-1:0], want.red);
            if (rsp_tdata[2*FIELD_W-1:FIELD_W] !== want.green)
               report_mismatch("green_out", rsp_tdata[2*FIELD_W-1:FIELD_W], want.green);
            if (rsp_tdata[3*FIELD_W-1:2*FIELD_W] !== want.blue)
               report_mismatch("blue_out", rsp_tdata[3*FIELD_W-1:2*FIELD_W], want.blue);
            if (rsp_tuser !== want.is_maximum)
               report_mismatch("is_maximum", FIELD_W'(rsp_tuser), FIELD_W'(want.is_maximum));
            if (rsp_tlast !== want.frame_end)
               report_mismatch("frame_end", FIELD_W'(rsp_tlast), FIELD_W'(want.frame_end));
         end
      end
      rsp_tready <= gaps_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
   end

   task automatic send_beat(input bit flush, input logic [PIX_W-1:0] pixel);
      while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= flush;
      req_tdata  <= pixel;
      do @(posedge clock); while (!req_tready);
      predict_marked_pixel(flush, pixel);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      apply_register(index, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Stops the req stream and lets every pending result drain out.
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Pushes out the pixels still held in the line stores; some of the
   // release beats are pixels, which the block treats as flushes here.
   task automatic release_frame(input int unsigned beyond_pct);
      while (next_row >= active_height())
         send_beat($urandom_range(99) >= beyond_pct, random_pixel(0));
   endtask

   task automatic send_frame(input int unsigned red_span, input int unsigned noise_pct,
                             input int unsigned beyond_pct);
      while (next_row < active_height()) begin
         if ($urandom_range(99) < noise_pct) send_beat(1'b1, random_pixel(0));
         send_beat(1'b0, random_pixel(red_span));
      end
      release_frame(beyond_pct);
   endtask

   task automatic test_directed();
      logic [PIX_W-1:0] pixel;
      gaps_on = 1'b1;
      write_register(CSR_FRAME_WIDTH, 16'd3);
      write_register(CSR_FRAME_HEIGHT, 16'd3);
      write_register(CSR_MARKER_VALUE, 16'hFFFF);
      write_register(CSR_UNUSED, 16'hFFFF);
      // Brightest possible center against neighbors one step darker.
      for (int i = 0; i < 9; i++) begin
         if (i == 4) pixel = {16'hFFFF, 16'hFFFF, 16'hFFFF};
         else if (i % 2 == 1) pixel = {16'hFFFF, 16'h0000, 16'hFFFE};
         else pixel = {16'h0000, 16'hFFFF, 16'hFFFE};
         send_beat(1'b0, pixel);
         if (i == 2) send_beat(1'b1, '1);
      end
      send_beat(1'b0, '1);
      release_frame(0);
      settle_block();
      // Zero sizes act as a single-pixel frame.
      write_register(CSR_FRAME_WIDTH, 16'd0);
      write_register(CSR_FRAME_HEIGHT, 16'd0);
      send_beat(1'b0, '0);
      release_frame(0);
   endtask

   // Oversized frames are clamped; they are cut short and dropped by the
   // next size write so that the run stays short.
   task automatic test_size_limits();
      settle_block();
      gaps_on = 1'b1;
      write_register(CSR_MARKER_VALUE, 16'h0000);
      write_register(CSR_FRAME_WIDTH, 16'd2047);
      write_register(CSR_FRAME_HEIGHT, 16'd2);
      for (int i = 0; i < 24; i++) send_beat(1'b0, random_pixel(0));
      settle_block();
      write_register(CSR_MARKER_VALUE, 16'hFFFF);
      write_register(CSR_FRAME_WIDTH, 16'd1);
      write_register(CSR_FRAME_HEIGHT, 16'd8191);
      for (int i = 0; i < 40; i++) send_beat(1'b0, random_pixel(1));
      settle_block();
      write_register(CSR_FRAME_WIDTH, 16'd2);
      write_register(CSR_FRAME_HEIGHT, 16'd2);
      send_frame(0, 20, 50);
   endtask

   // The sender holds off mid-frame until every released pixel is out,
   // then moves the marker level while the block sits idle.
   task automatic test_drain_pause();
      int unsigned count;
      settle_block();
      gaps_on = 1'b1;
      write_register(CSR_FRAME_WIDTH, 16'd6);
      write_register(CSR_FRAME_HEIGHT, 16'd5);
      count = 0;
      while (next_row < active_height()) begin
         send_beat(1'b0, random_pixel(2));
         count++;
         if (count % 7 == 0) begin
            settle_block();
            write_register(CSR_MARKER_VALUE, 16'($urandom));
         end
      end
      release_frame(20);
   endtask

   task automatic test_random_frames();
      int unsigned start, done, span, pixels;
      logic [CSR_DATA_W-1:0] data;
      start = effective_beats;
      while (effective_beats - start < RANDOM_BEATS) begin
         settle_block();
         done = effective_beats - start;
         gaps_on = !(done >= 300 && done < 450);
         data = 16'($urandom);
         case ($urandom_range(9))
            0: data[WIDTH_REG_W-1:0] = '0;
            1: data[WIDTH_REG_W-1:0] = WIDTH_REG_W'(1);
            2: data[WIDTH_REG_W-1:0] = WIDTH_REG_W'(2);
            3: data[WIDTH_REG_W-1:0] = WIDTH_REG_W'($urandom_range(10, 24));
            default: data[WIDTH_REG_W-1:0] = WIDTH_REG_W'($urandom_range(3, 8));
         endcase
         write_register(CSR_FRAME_WIDTH, data);
         data = 16'($urandom);
         case ($urandom_range(9))
            0: data[HEIGHT_REG_W-1:0] = '0;
            1: data[HEIGHT_REG_W-1:0] = HEIGHT_REG_W'(1);
            2: data[HEIGHT_REG_W-1:0] = HEIGHT_REG_W'(2);
            3: data[HEIGHT_REG_W-1:0] = HEIGHT_REG_W'($urandom_range(9, 16));
            default: data[HEIGHT_REG_W-1:0] = HEIGHT_REG_W'($urandom_range(3, 8));
         endcase
         write_register(CSR_FRAME_HEIGHT, data);
         case ($urandom_range(7))
            0: write_register(CSR_MARKER_VALUE, 16'h0000);
            1: write_register(CSR_MARKER_VALUE, 16'hFFFF);
            default: write_register(CSR_MARKER_VALUE, 16'($urandom));
         endcase
         if ($urandom_range(9) == 0) write_register(CSR_UNUSED, 16'($urandom));
         case ($urandom_range(3))
            0: span = 0;
            1: span = 1;
            default: span = 3;
         endcase
         if ($urandom_range(9) == 0) begin
            // Broken frame: cut short and dropped by the next size write.
            pixels = $urandom_range(active_width() * active_height() - 1);
            for (int i = 0; i < pixels; i++) begin
               if ($urandom_range(99) < 10) send_beat(1'b1, random_pixel(0));
               send_beat(1'b0, random_pixel(span));
            end
         end else begin
            send_frame(span, 5, 20);
         end
      end
   endtask

   initial begin
      reset_prediction();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_size_limits();
      test_drain_pause();
      test_random_frames();
      settle_block();
      if (error_count == 0) begin
         $display("local_maximum_marker_3x3_tb: clean");
      end else begin
         $display("local_maximum_marker_3x3_tb: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
